/* design/bucketed_hash_table_depth_replace_top_defines.svh */
// Assertion macros used by the hash table top module.
`ifndef BUCKETED_HASH_TABLE_DEPTH_REPLACE_TOP_DEFINES_SVH
`define BUCKETED_HASH_TABLE_DEPTH_REPLACE_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BHTDR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BHTDR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/bhtdr_pkg.sv */
// Types and constants shared by the bucketed hash table modules.
`default_nettype none
package bhtdr_pkg;

    localparam int BUCKETS_DEF      = 4096;
    localparam int WAYS_DEF         = 4;
    localparam int PAYLOAD_BITS_DEF = 32;
    localparam int QUEUE_DEPTH      = 4;
    localparam int KEY_W            = 64;
    localparam int DEPTH_W          = 8;
    localparam int PAY_W            = 32;
    localparam int HASH_W           = 32;

    localparam logic [1:0] CMD_STORE  = 2'd0;
    localparam logic [1:0] CMD_LOOKUP = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    typedef struct packed {
        logic [1:0]         command;
        logic [KEY_W-1:0]   key;
        logic [DEPTH_W-1:0] depth;
        logic [PAY_W-1:0]   payload;
        logic               replace_any;
    } t_in_beat;

    typedef struct packed {
        logic               found;
        logic [KEY_W-1:0]   hit_key;
        logic [DEPTH_W-1:0] hit_depth;
        logic [PAY_W-1:0]   hit_payload;
    } t_out_beat;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

    typedef struct packed {
        logic clearing;
    } t_back_stat;

endpackage
`default_nettype wire

/* design/bhtdr_front.sv */
// Front end: accepts beats, drops unused commands and computes the bucket index.
`default_nettype none
module bhtdr_front #(
    parameter int BUCKETS = bhtdr_pkg::BUCKETS_DEF,
    parameter int BW      = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_stall,
    input  bhtdr_pkg::t_in_beat  i_beat,
    output logic                 o_push,
    output bhtdr_pkg::t_in_beat  o_beat,
    output logic [BW-1:0]        o_bucket,
    input  bhtdr_pkg::t_q_stat   i_qstat
);
    import bhtdr_pkg::*;

    localparam int PW = HASH_W + $clog2(BUCKETS + 1);

    logic           r_vld;
    logic           n_vld;
    t_in_beat       r_beat;
    logic [BW-1:0]  r_bucket;
    logic [PW-1:0]  w_prod;
    logic           w_accept;
    logic           w_keep;

    // Bucket is the high part of the low key word scaled by the bucket count.
    assign w_prod   = PW'(i_beat.key[HASH_W-1:0]) * PW'(BUCKETS);
    assign o_push   = r_vld && !i_qstat.full;
    assign o_stall  = r_vld && i_qstat.full;
    assign w_accept = i_valid && !o_stall;
    assign o_beat   = r_beat;
    assign o_bucket = r_bucket;

    always_comb begin
        case (i_beat.command)
            CMD_STORE, CMD_LOOKUP, CMD_CLEAR: w_keep = 1'b1;
            default:                          w_keep = 1'b0;
        endcase
    end

    always_comb begin
        n_vld = r_vld;
        if (w_accept && w_keep) begin
            n_vld = 1'b1;
        end else if (o_push) begin
            n_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_keep) begin
            r_beat   <= i_beat;
            r_bucket <= w_prod[HASH_W +: BW];
        end
    end

endmodule
`default_nettype wire

/* design/bhtdr_queue.sv */
// Small register queue between the front end and the table engine.
`default_nettype none
module bhtdr_queue #(
    parameter int W     = 8,
    parameter int DEPTH = bhtdr_pkg::QUEUE_DEPTH
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  wire  [W-1:0]        i_data,
    input  wire                 i_pop,
    output logic [W-1:0]        o_data,
    output bhtdr_pkg::t_q_stat  o_stat
);
    import bhtdr_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wp;
    logic [AW-1:0] r_rp;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] n_cnt;

    function automatic logic [AW-1:0] f_adv(input logic [AW-1:0] p);
        f_adv = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    assign o_data       = r_mem[r_rp];
    assign o_stat.empty = (r_cnt == '0);
    assign o_stat.full  = (r_cnt == CW'(DEPTH));

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wp <= f_adv(r_wp);
            end
            if (i_pop) begin
                r_rp <= f_adv(r_rp);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule
`default_nettype wire

/* design/bhtdr_back.sv */
// Table engine: bucket row memory, read-modify-write of stores, lookups and clear sweep.
`default_nettype none
module bhtdr_back #(
    parameter int BUCKETS      = bhtdr_pkg::BUCKETS_DEF,
    parameter int WAYS         = bhtdr_pkg::WAYS_DEF,
    parameter int PAYLOAD_BITS = bhtdr_pkg::PAYLOAD_BITS_DEF,
    parameter int BW           = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  bhtdr_pkg::t_q_stat     i_qstat,
    input  bhtdr_pkg::t_in_beat    i_beat,
    input  wire  [BW-1:0]          i_bucket,
    output logic                   o_pop,
    output logic                   o_valid,
    input  wire                    i_stall,
    output bhtdr_pkg::t_out_beat   o_beat,
    output bhtdr_pkg::t_back_stat  o_stat
);
    import bhtdr_pkg::*;

    localparam int WB = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int FW = $clog2(WAYS + 1);
    localparam int PB = PAYLOAD_BITS;

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_ISSUE = 3'b010,
        ST_EXEC  = 3'b100
    } t_state;

    logic [WAYS-1:0][KEY_W-1:0]   mem_key [BUCKETS];
    logic [WAYS-1:0][DEPTH_W-1:0] mem_dep [BUCKETS];
    logic [WAYS-1:0][PB-1:0]      mem_pay [BUCKETS];
    logic [FW-1:0]                mem_fill [BUCKETS];

    t_state                       r_state;
    t_state                       n_state;
    logic [BW-1:0]                r_cnt;
    logic [BW-1:0]                n_cnt;
    t_in_beat                     r_cur;
    logic [BW-1:0]                r_bkt;
    logic [WAYS-1:0][KEY_W-1:0]   r_rd_key;
    logic [WAYS-1:0][DEPTH_W-1:0] r_rd_dep;
    logic [WAYS-1:0][PB-1:0]      r_rd_pay;
    logic [FW-1:0]                r_rd_fill;
    logic                         r_ovld;
    logic                         n_ovld;
    t_out_beat                    r_obeat;

    logic                         w_rd_en;
    logic                         w_wr_en;
    logic [BW-1:0]                w_wr_addr;
    logic [WAYS-1:0][KEY_W-1:0]   w_wr_key;
    logic [WAYS-1:0][DEPTH_W-1:0] w_wr_dep;
    logic [WAYS-1:0][PB-1:0]      w_wr_pay;
    logic [FW-1:0]                w_wr_fill;
    logic                         w_rep_ok;
    logic [WB-1:0]                w_rep_way;
    logic                         w_lk_hit;
    logic [WB-1:0]                w_lk_way;
    logic                         w_has_free;
    logic                         w_put;
    logic [WB-1:0]                w_put_way;
    logic                         w_load_out;

    assign o_valid         = r_ovld;
    assign o_beat          = r_obeat;
    assign o_stat.clearing = (r_state == ST_CLEAR);
    assign w_has_free      = (r_rd_fill < FW'(WAYS));

    // Replacement victim in a full bucket and the first matching way of a lookup.
    always_comb begin
        w_rep_ok  = 1'b0;
        w_rep_way = '0;
        w_lk_hit  = 1'b0;
        w_lk_way  = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (!w_rep_ok && (r_rd_key[w] == r_cur.key || r_rd_dep[w] <= r_cur.depth
                              || r_cur.replace_any)) begin
                w_rep_ok  = 1'b1;
                w_rep_way = WB'(w);
            end
            if (!w_lk_hit && r_rd_key[w] == r_cur.key) begin
                w_lk_hit = 1'b1;
                w_lk_way = WB'(w);
            end
        end
    end

    assign w_put     = w_has_free || w_rep_ok;
    assign w_put_way = w_has_free ? WB'(r_rd_fill) : w_rep_way;

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_pop      = 1'b0;
        w_rd_en    = 1'b0;
        w_wr_en    = 1'b0;
        w_wr_addr  = r_bkt;
        w_wr_key   = r_rd_key;
        w_wr_dep   = r_rd_dep;
        w_wr_pay   = r_rd_pay;
        w_wr_fill  = r_rd_fill;
        w_load_out = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_cnt;
                w_wr_key  = '0;
                w_wr_dep  = '0;
                w_wr_pay  = '0;
                w_wr_fill = '0;
                if (r_cnt == BW'(BUCKETS - 1)) begin
                    n_state = ST_ISSUE;
                end else begin
                    n_cnt = r_cnt + BW'(1);
                end
            end
            ST_ISSUE: begin
                if (!i_qstat.empty) begin
                    o_pop = 1'b1;
                    if (i_beat.command == CMD_CLEAR) begin
                        n_state = ST_CLEAR;
                        n_cnt   = '0;
                    end else begin
                        w_rd_en = 1'b1;
                        n_state = ST_EXEC;
                    end
                end
            end
            ST_EXEC: begin
                if (r_cur.command == CMD_LOOKUP) begin
                    if (!r_ovld || !i_stall) begin
                        w_load_out = 1'b1;
                        n_state    = ST_ISSUE;
                    end
                end else begin
                    w_wr_en = w_put;
                    w_wr_key[w_put_way] = r_cur.key;
                    w_wr_dep[w_put_way] = r_cur.depth;
                    w_wr_pay[w_put_way] = PB'(r_cur.payload);
                    if (w_has_free) begin
                        w_wr_fill = r_rd_fill + FW'(1);
                    end
                    n_state = ST_ISSUE;
                end
            end
            default: begin
                n_state = ST_ISSUE;
            end
        endcase
    end

    always_comb begin
        n_ovld = r_ovld;
        if (w_load_out) begin
            n_ovld = 1'b1;
        end else if (r_ovld && !i_stall) begin
            n_ovld = 1'b0;
        end
    end

    // The whole table is wiped after reset, one bucket row per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_cnt   <= '0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_ovld  <= n_ovld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur <= i_beat;
            r_bkt <= i_bucket;
        end
        if (w_load_out) begin
            r_obeat.found       <= w_lk_hit;
            r_obeat.hit_key     <= r_rd_key[w_lk_way];
            r_obeat.hit_depth   <= r_rd_dep[w_lk_way];
            r_obeat.hit_payload <= PAY_W'(r_rd_pay[w_lk_way]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rd_key  <= mem_key[i_bucket];
            r_rd_dep  <= mem_dep[i_bucket];
            r_rd_pay  <= mem_pay[i_bucket];
            r_rd_fill <= mem_fill[i_bucket];
        end
        if (w_wr_en) begin
            mem_key[w_wr_addr]  <= w_wr_key;
            mem_dep[w_wr_addr]  <= w_wr_dep;
            mem_pay[w_wr_addr]  <= w_wr_pay;
            mem_fill[w_wr_addr] <= w_wr_fill;
        end
    end

endmodule
`default_nettype wire

/* design/bucketed_hash_table_depth_replace_top.sv */
// A lookup beat passes the front register, the queue, the bucket row read and the output register.
// The engine takes one store or lookup at a time: it reads the bucket row, then for a store writes it back.
// A clear command sweeps all BUCKETS rows, one bucket row written per cycle.
// Reset starts the same wipe; beats are queued meanwhile, none executed.
// Stores and clears give no output beat; unused command codes are dropped on entry.
`default_nettype none
`include "bucketed_hash_table_depth_replace_top_defines.svh"
module bucketed_hash_table_depth_replace_top #(
    parameter int BUCKETS      = bhtdr_pkg::BUCKETS_DEF,
    parameter int WAYS         = bhtdr_pkg::WAYS_DEF,
    parameter int PAYLOAD_BITS = bhtdr_pkg::PAYLOAD_BITS_DEF
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_valid,
    output logic                  o_stall,
    input  bhtdr_pkg::t_in_beat   i_beat,
    output logic                  o_valid,
    input  wire                   i_stall,
    output bhtdr_pkg::t_out_beat  o_beat
);
    import bhtdr_pkg::*;

    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int QW = $bits(t_in_beat) + BW;

    logic          w_push;
    t_in_beat      w_f_beat;
    logic [BW-1:0] w_f_bkt;
    logic [QW-1:0] w_q_in;
    logic [QW-1:0] w_q_out;
    t_in_beat      w_q_beat;
    logic [BW-1:0] w_q_bkt;
    logic          w_pop;
    logic          w_clr_pop;
    t_q_stat       w_qstat;
    t_back_stat    w_bstat;

    assign w_q_in    = {w_f_beat, w_f_bkt};
    assign w_q_beat  = w_q_out[QW-1:BW];
    assign w_q_bkt   = w_q_out[BW-1:0];
    assign w_clr_pop = w_pop && (w_q_beat.command == CMD_CLEAR);

    bhtdr_front #(
        .BUCKETS (BUCKETS),
        .BW      (BW)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_beat   (i_beat),
        .o_push   (w_push),
        .o_beat   (w_f_beat),
        .o_bucket (w_f_bkt),
        .i_qstat  (w_qstat)
    );

    bhtdr_queue #(
        .W     (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_q_in),
        .i_pop   (w_pop),
        .o_data  (w_q_out),
        .o_stat  (w_qstat)
    );

    bhtdr_back #(
        .BUCKETS      (BUCKETS),
        .WAYS         (WAYS),
        .PAYLOAD_BITS (PAYLOAD_BITS),
        .BW           (BW)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_qstat  (w_qstat),
        .i_beat   (w_q_beat),
        .i_bucket (w_q_bkt),
        .o_pop    (w_pop),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_beat   (o_beat),
        .o_stat   (w_bstat)
    );

    `BHTDR_ASSERT_NOW(a_pop_not_empty, w_pop, !w_qstat.empty, "queue popped while empty")
    `BHTDR_ASSERT_NOW(a_push_not_full, w_push, !w_qstat.full, "queue pushed while full")
    `BHTDR_ASSERT_NOW(a_no_pop_clearing, w_bstat.clearing, !w_pop, "queue popped during clear")
    `BHTDR_ASSERT_NEXT(a_clear_starts, w_clr_pop, w_bstat.clearing, "clear did not start sweep")

endmodule
`default_nettype wire
